// File: sv/pimrp_pkg.sv
package pimrp_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int COUNT_W   = 16;
  localparam int EPS_W     = 17;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int CHUNK_W   = DIFF_W - 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int ACC_W     = 4 * CHUNK_W;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RAY_DIR_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 3'd6;

  // Edge vectors and origin offset of one triangle, as the front prepares them.
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] e1;
    logic [2:0][DIFF_W-1:0] e2;
    logic [2:0][DIFF_W-1:0] s;
    logic                   last;
  } tri_t;

  typedef struct packed {
    logic hit;
    logic last;
  } res_t;

  typedef struct packed {
    logic       vld;
    logic       first;
    logic       sub;
    logic       base_t;
    logic [1:0] chunk;
    logic [2:0] dst;
    logic [1:0] idx;
  } mac_ctl_t;

  // One 32-bit slice of a wide value as a 33-bit signed multiplier operand.
  // Only the slice flagged by top carries the sign; the others are zero-extended.
  function automatic logic [DIFF_W-1:0] chunk_of(input logic [ACC_W-1:0] v,
                                                 input logic [1:0] k,
                                                 input logic top);
    logic [CHUNK_W-1:0] c;
    case (k)
      2'd0:    c = v[CHUNK_W-1:0];
      2'd1:    c = v[2*CHUNK_W-1:CHUNK_W];
      2'd2:    c = v[3*CHUNK_W-1:2*CHUNK_W];
      default: c = v[4*CHUNK_W-1:3*CHUNK_W];
    endcase
    return {top & c[CHUNK_W-1], c};
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] i);
    return (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

endpackage

// File: sv/point_in_mesh_ray_parity.sv
// Point-in-mesh test by ray parity. A ray leaves the configured query point
// along the configured direction; each triangle of the mesh streams in as one
// request on the in_ channel (three vertices, Q16.16) and is tested for a
// crossing. Crossings are counted, saturating. The request flagged as the last
// triangle produces one result request on the out_ channel: the count and its
// parity (odd means inside); the count then starts again from zero. Other
// triangles produce no result.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) and is
// to be written only while the block is idle; the block does not enforce this.
// A front stage forms edge vectors and the origin offset, a two-entry queue
// holds prepared triangles, and an engine runs the test on one shared 33x33
// multiplier with an accumulator. The engine works on one triangle at a time
// and takes the next only once its result has been handed on. Up to three
// triangles wait in front of the engine.
// A stalled result sits in the output register; the engine finishes the next
// triangle and then holds it until the output register is taken.
// Reset (rst_n low, synchronous) empties the pipeline, clears the count and
// restores origin 0, direction (1.0, 0, 0) and epsilon 1.
module point_in_mesh_ray_parity import pimrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_a_x,
  input  logic [COORD_W-1:0]   in_a_y,
  input  logic [COORD_W-1:0]   in_a_z,
  input  logic [COORD_W-1:0]   in_b_x,
  input  logic [COORD_W-1:0]   in_b_y,
  input  logic [COORD_W-1:0]   in_b_z,
  input  logic [COORD_W-1:0]   in_c_x,
  input  logic [COORD_W-1:0]   in_c_y,
  input  logic [COORD_W-1:0]   in_c_z,
  input  logic                 in_last_triangle,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_inside_res,
  output logic [COUNT_W-1:0]   out_hit_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  logic [COORD_W-1:0] qx_r, qy_r, qz_r, dx_r, dy_r, dz_r;
  logic [EPS_W-1:0]   eps_r;

  logic tri_valid, tri_ready, q_valid, q_ready, res_valid, res_ready;
  tri_t tri_data, q_data;
  res_t res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r  <= '0;
      qy_r  <= '0;
      qz_r  <= '0;
      dx_r  <= COORD_W'(1) << FRAC_BITS;
      dy_r  <= '0;
      dz_r  <= '0;
      eps_r <= EPS_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_X:   qx_r  <= cfg_wdata;
        CFG_QUERY_Y:   qy_r  <= cfg_wdata;
        CFG_QUERY_Z:   qz_r  <= cfg_wdata;
        CFG_RAY_DIR_X: dx_r  <= cfg_wdata;
        CFG_RAY_DIR_Y: dy_r  <= cfg_wdata;
        CFG_RAY_DIR_Z: dz_r  <= cfg_wdata;
        CFG_EPSILON:   eps_r <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  pimrp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_a_x           (in_a_x),
    .in_a_y           (in_a_y),
    .in_a_z           (in_a_z),
    .in_b_x           (in_b_x),
    .in_b_y           (in_b_y),
    .in_b_z           (in_b_z),
    .in_c_x           (in_c_x),
    .in_c_y           (in_c_y),
    .in_c_z           (in_c_z),
    .in_last_triangle (in_last_triangle),
    .query_x          (qx_r),
    .query_y          (qy_r),
    .query_z          (qz_r),
    .tri_valid        (tri_valid),
    .tri_ready        (tri_ready),
    .tri_data         (tri_data)
  );

  pimrp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (tri_valid),
    .wr_ready (tri_ready),
    .wr_data  (tri_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  pimrp_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray_dir_x (dx_r),
    .ray_dir_y (dy_r),
    .ray_dir_z (dz_r),
    .epsilon   (eps_r),
    .tri_valid (q_valid),
    .tri_ready (q_ready),
    .tri_data  (q_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  pimrp_count u_count (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_data       (res_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_hit_count  (out_hit_count)
  );

endmodule

// File: sv/pimrp_front.sv
module pimrp_front import pimrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_a_x,
  input  logic [COORD_W-1:0] in_a_y,
  input  logic [COORD_W-1:0] in_a_z,
  input  logic [COORD_W-1:0] in_b_x,
  input  logic [COORD_W-1:0] in_b_y,
  input  logic [COORD_W-1:0] in_b_z,
  input  logic [COORD_W-1:0] in_c_x,
  input  logic [COORD_W-1:0] in_c_y,
  input  logic [COORD_W-1:0] in_c_z,
  input  logic               in_last_triangle,
  input  logic [COORD_W-1:0] query_x,
  input  logic [COORD_W-1:0] query_y,
  input  logic [COORD_W-1:0] query_z,
  output logic               tri_valid,
  input  logic               tri_ready,
  output tri_t               tri_data
);

  logic vld_r, vld_nxt;
  tri_t data_r, data_nxt;
  logic accept;

  assign in_ready = !vld_r || tri_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    data_nxt       = data_r;
    data_nxt.e1[0] = {in_b_x[COORD_W-1], in_b_x} - {in_a_x[COORD_W-1], in_a_x};
    data_nxt.e1[1] = {in_b_y[COORD_W-1], in_b_y} - {in_a_y[COORD_W-1], in_a_y};
    data_nxt.e1[2] = {in_b_z[COORD_W-1], in_b_z} - {in_a_z[COORD_W-1], in_a_z};
    data_nxt.e2[0] = {in_c_x[COORD_W-1], in_c_x} - {in_a_x[COORD_W-1], in_a_x};
    data_nxt.e2[1] = {in_c_y[COORD_W-1], in_c_y} - {in_a_y[COORD_W-1], in_a_y};
    data_nxt.e2[2] = {in_c_z[COORD_W-1], in_c_z} - {in_a_z[COORD_W-1], in_a_z};
    data_nxt.s[0]  = {query_x[COORD_W-1], query_x} - {in_a_x[COORD_W-1], in_a_x};
    data_nxt.s[1]  = {query_y[COORD_W-1], query_y} - {in_a_y[COORD_W-1], in_a_y};
    data_nxt.s[2]  = {query_z[COORD_W-1], query_z} - {in_a_z[COORD_W-1], in_a_z};
    data_nxt.last  = in_last_triangle;
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (tri_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign tri_valid = vld_r;
  assign tri_data  = data_r;

endmodule

// File: sv/pimrp_fifo.sv
module pimrp_fifo import pimrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  tri_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output tri_t rd_data
);

  tri_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QPTR_W'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QPTR_W'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wr_data;
    end
  end

endmodule

// File: sv/pimrp_engine.sv
module pimrp_engine import pimrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COORD_W-1:0] ray_dir_x,
  input  logic [COORD_W-1:0] ray_dir_y,
  input  logic [COORD_W-1:0] ray_dir_z,
  input  logic [EPS_W-1:0]   epsilon,
  input  logic               tri_valid,
  output logic               tri_ready,
  input  tri_t               tri_data,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res_data
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_CRH   = 4'd1;
  localparam logic [3:0] PH_CRQ   = 4'd2;
  localparam logic [3:0] PH_DD    = 4'd3;
  localparam logic [3:0] PH_DU    = 4'd4;
  localparam logic [3:0] PH_DV    = 4'd5;
  localparam logic [3:0] PH_DT    = 4'd6;
  localparam logic [3:0] PH_EPS   = 4'd7;
  localparam logic [3:0] PH_DRAIN = 4'd8;
  localparam logic [3:0] PH_CHK1  = 4'd9;
  localparam logic [3:0] PH_CHK2  = 4'd10;
  localparam logic [3:0] PH_DONE  = 4'd11;

  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_H    = 3'd1;
  localparam logic [2:0] DST_Q    = 3'd2;
  localparam logic [2:0] DST_D    = 3'd3;
  localparam logic [2:0] DST_U    = 3'd4;
  localparam logic [2:0] DST_V    = 3'd5;
  localparam logic [2:0] DST_T    = 3'd6;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] i_r, i_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] kmax;

  logic [2:0][DIFF_W-1:0] e1_r, e2_r, s_r, dir_w;
  logic                   last_r;
  logic [2:0][ACC_W-1:0]  h_r, q_r;
  logic [ACC_W-1:0]       d_r, u_r, v_r, t_r, acc_r, acc_nxt, uv_r;
  logic                   miss_r, rgood_r, hit_r;

  logic [1:0]        idx1, idx2;
  logic [DIFF_W-1:0] a_op, b_op;
  mac_ctl_t          ctl, ctl2_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  ext, sh, base;

  logic signed [ACC_W-1:0] d_s, u_s, v_s, r_s, uv_s, eps_big, eps_neg;
  logic                    dneg, par_miss, u_bad, v_bad, r_good, uv_bad;

  assign dir_w[0] = {ray_dir_x[COORD_W-1], ray_dir_x};
  assign dir_w[1] = {ray_dir_y[COORD_W-1], ray_dir_y};
  assign dir_w[2] = {ray_dir_z[COORD_W-1], ray_dir_z};

  assign idx1 = inc3(i_r);
  assign idx2 = inc3(idx1);

  // Operand selection for the shared multiplier. Cross products take two
  // terms per component; dot products take three slices of the wide factor.
  always_comb begin
    a_op       = '0;
    b_op       = '0;
    ctl        = '0;
    ctl.chunk  = k_r;
    ctl.idx    = i_r;
    ctl.first  = (i_r == 2'd0) && (k_r == 2'd0);
    ctl.dst    = DST_NONE;
    case (phase_r)
      PH_CRH, PH_CRQ: begin
        ctl.vld   = 1'b1;
        ctl.chunk = 2'd0;
        ctl.first = !k_r[0];
        ctl.sub   = k_r[0];
        if (phase_r == PH_CRH) begin
          a_op    = k_r[0] ? dir_w[idx2] : dir_w[idx1];
          b_op    = k_r[0] ? e2_r[idx1] : e2_r[idx2];
          ctl.dst = k_r[0] ? DST_H : DST_NONE;
        end else begin
          a_op    = k_r[0] ? s_r[idx2] : s_r[idx1];
          b_op    = k_r[0] ? e1_r[idx1] : e1_r[idx2];
          ctl.dst = k_r[0] ? DST_Q : DST_NONE;
        end
      end
      PH_DD: begin
        ctl.vld = 1'b1;
        a_op    = e1_r[i_r];
        b_op    = chunk_of(h_r[i_r], k_r, k_r == 2'd2);
        ctl.dst = (i_r == 2'd2 && k_r == 2'd2) ? DST_D : DST_NONE;
      end
      PH_DU: begin
        ctl.vld = 1'b1;
        a_op    = s_r[i_r];
        b_op    = chunk_of(h_r[i_r], k_r, k_r == 2'd2);
        ctl.dst = (i_r == 2'd2 && k_r == 2'd2) ? DST_U : DST_NONE;
      end
      PH_DV: begin
        ctl.vld = 1'b1;
        a_op    = dir_w[i_r];
        b_op    = chunk_of(q_r[i_r], k_r, k_r == 2'd2);
        ctl.dst = (i_r == 2'd2 && k_r == 2'd2) ? DST_V : DST_NONE;
      end
      PH_DT: begin
        ctl.vld = 1'b1;
        a_op    = e2_r[i_r];
        b_op    = chunk_of(q_r[i_r], k_r, k_r == 2'd2);
        ctl.dst = (i_r == 2'd2 && k_r == 2'd2) ? DST_T : DST_NONE;
      end
      PH_EPS: begin
        // Forms T * 2^FRAC - eps * D on the raw, uncorrected values.
        ctl.vld    = 1'b1;
        ctl.first  = 1'b0;
        ctl.base_t = (k_r == 2'd0);
        ctl.sub    = 1'b1;
        a_op       = DIFF_W'(epsilon);
        b_op       = chunk_of(d_r, k_r, k_r == 2'd3);
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_CRH, PH_CRQ: kmax = 2'd1;
      PH_EPS:         kmax = 2'd3;
      default:        kmax = 2'd2;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    case (phase_r)
      PH_IDLE: begin
        i_nxt = 2'd0;
        k_nxt = 2'd0;
        if (tri_valid) begin
          phase_nxt = PH_CRH;
        end
      end
      PH_CRH, PH_CRQ, PH_DD, PH_DU, PH_DV, PH_DT, PH_EPS: begin
        if (k_r == kmax) begin
          k_nxt = 2'd0;
          if (phase_r == PH_EPS || i_r == 2'd2) begin
            i_nxt     = 2'd0;
            phase_nxt = phase_r + 4'd1;
          end else begin
            i_nxt = i_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      PH_DRAIN: phase_nxt = PH_CHK1;
      PH_CHK1:  phase_nxt = PH_CHK2;
      PH_CHK2:  phase_nxt = PH_DONE;
      PH_DONE: begin
        if (res_ready) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Accumulate stage: the product is placed at its slice and added or
  // subtracted, starting from zero, from the running sum or from T.
  always_comb begin
    ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    case (ctl2_r.chunk)
      2'd0:    sh = ext;
      2'd1:    sh = ext << CHUNK_W;
      2'd2:    sh = ext << (2 * CHUNK_W);
      default: sh = ext << (3 * CHUNK_W);
    endcase
    if (ctl2_r.first) begin
      base = '0;
    end else if (ctl2_r.base_t) begin
      base = t_r << FRAC_BITS;
    end else begin
      base = acc_r;
    end
    acc_nxt = base + (sh ^ {ACC_W{ctl2_r.sub}}) + ACC_W'(ctl2_r.sub);
  end

  // Sign correction is folded into the compares: with D negative every
  // inequality flips instead of negating D, U, V and T.
  assign d_s     = d_r;
  assign u_s     = u_r;
  assign v_s     = v_r;
  assign r_s     = acc_r;
  assign uv_s    = uv_r;
  assign dneg    = d_r[ACC_W-1];
  assign eps_big = ACC_W'(epsilon) << (2 * FRAC_BITS);
  assign eps_neg = -eps_big;

  assign par_miss = dneg ? (d_s > eps_neg) : (d_s < eps_big);
  assign u_bad    = dneg ? ((u_s > 0) || (u_s < d_s)) : ((u_s < 0) || (u_s > d_s));
  assign v_bad    = dneg ? (v_s > 0) : (v_s < 0);
  assign r_good   = dneg ? (r_s < 0) : (r_s > 0);
  assign uv_bad   = dneg ? (uv_s < d_s) : (uv_s > d_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      i_r     <= 2'd0;
      k_r     <= 2'd0;
      ctl2_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      k_r     <= k_nxt;
      ctl2_r  <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'($signed(a_op) * $signed(b_op));
    if (phase_r == PH_IDLE && tri_valid) begin
      e1_r   <= tri_data.e1;
      e2_r   <= tri_data.e2;
      s_r    <= tri_data.s;
      last_r <= tri_data.last;
    end
    if (ctl2_r.vld) begin
      acc_r <= acc_nxt;
      case (ctl2_r.dst)
        DST_H:   h_r[ctl2_r.idx] <= acc_nxt;
        DST_Q:   q_r[ctl2_r.idx] <= acc_nxt;
        DST_D:   d_r <= acc_nxt;
        DST_U:   u_r <= acc_nxt;
        DST_V:   v_r <= acc_nxt;
        DST_T:   t_r <= acc_nxt;
        default: ;
      endcase
    end
    if (phase_r == PH_CHK1) begin
      uv_r    <= u_r + v_r;
      miss_r  <= par_miss || u_bad || v_bad;
      rgood_r <= r_good;
    end
    if (phase_r == PH_CHK2) begin
      hit_r <= !miss_r && rgood_r && !uv_bad;
    end
  end

  assign tri_ready     = (phase_r == PH_IDLE);
  assign res_valid     = (phase_r == PH_DONE);
  assign res_data.hit  = hit_r;
  assign res_data.last = last_r;

endmodule

// File: sv/pimrp_count.sv
module pimrp_count import pimrp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  res_t               res_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_inside_res,
  output logic [COUNT_W-1:0] out_hit_count
);

  logic [COUNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic               ovld_r, ovld_nxt;
  logic [COUNT_W-1:0] ocnt_r;
  logic               take;

  assign res_ready = !ovld_r || out_ready;
  assign take      = res_valid && res_ready;

  // The count saturates at its all-ones value.
  assign cnt_upd = (res_data.hit && (cnt_r != '1)) ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    cnt_nxt  = cnt_r;
    ovld_nxt = ovld_r;
    if (out_ready) begin
      ovld_nxt = 1'b0;
    end
    if (take) begin
      cnt_nxt = res_data.last ? '0 : cnt_upd;
      if (res_data.last) begin
        ovld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_data.last) begin
      ocnt_r <= cnt_upd;
    end
  end

  assign out_valid      = ovld_r;
  assign out_hit_count  = ocnt_r;
  assign out_inside_res = ocnt_r[0];

endmodule

// File: sv/pimrp_checker.sv
module pimrp_checker import pimrp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_inside_res,
  input logic [COUNT_W-1:0] out_hit_count
);

  // A stalled result keeps its count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit_count))
    else $error("result changed while stalled");

  // The inside flag is the parity of the reported count.
  a_parity: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_inside_res == out_hit_count[0])
    else $error("inside flag disagrees with count parity");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind point_in_mesh_ray_parity pimrp_checker u_pimrp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res),
  .out_hit_count  (out_hit_count)
);
